/* hdl/hfte_pkg.sv */
// ----------------------------------------------------------------------------
// hfte_pkg
// Shared types and constants for the half-float trough estimator.
// ----------------------------------------------------------------------------
package hfte_pkg;

    localparam int unsigned HALF_W      = 16;
    localparam int unsigned MAG_W       = 40;
    localparam int unsigned TROUGH_W    = 43;
    localparam int unsigned INTERVAL_W  = 8;

    localparam int unsigned MAX_CASCADES = 4;

    localparam logic [INTERVAL_W-1:0] SCAN_INTERVAL_RESET = INTERVAL_W'(15);

    localparam logic [HALF_W-1:0] HALF_EXP_MASK = 16'h7C00;
    localparam logic [HALF_W-1:0] HALF_MAG_MASK = 16'h7FFF;
    localparam logic [HALF_W-1:0] HALF_SIGN_BIT = 16'h8000;

    // largest finite half magnitude, 2^-24 units
    localparam logic [TROUGH_W-1:0] HALF_MAX_FIXED = TROUGH_W'(2047) << 29;
    localparam logic [TROUGH_W-1:0] TROUGH_CAP =
        TROUGH_W'(MAX_CASCADES) * HALF_MAX_FIXED;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_TEXEL = 1'b1;

    localparam logic KIND_DECISION = 1'b0;
    localparam logic KIND_TROUGH   = 1'b1;

    typedef struct packed {
        logic             neg_finite;
        logic             neg_inf;
        logic [MAG_W-1:0] mag;
    } hfte_decode_t;

endpackage

/* hdl/hfte_in_if.sv */
// ----------------------------------------------------------------------------
// hfte_in_if
// Input channel: frame ticks and height texels.
// ----------------------------------------------------------------------------
interface hfte_in_if;
    import hfte_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic              tile_ready;
    logic [HALF_W-1:0] height_half;
    logic              last_of_cascade;
    logic              last_of_tile;

    modport source
    (
        output valid, command, tile_ready, height_half, last_of_cascade, last_of_tile,
        input  ready
    );

    modport sink
    (
        input  valid, command, tile_ready, height_half, last_of_cascade, last_of_tile,
        output ready
    );

endinterface

/* hdl/hfte_out_if.sv */
// ----------------------------------------------------------------------------
// hfte_out_if
// Result channel: scan decisions and trough estimates.
// ----------------------------------------------------------------------------
interface hfte_out_if;
    import hfte_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic                scan_now;
    logic [TROUGH_W-1:0] trough;
    logic                trough_infinite;

    modport source
    (
        output valid, kind, scan_now, trough, trough_infinite,
        input  ready
    );

    modport sink
    (
        input  valid, kind, scan_now, trough, trough_infinite,
        output ready
    );

endinterface

/* hdl/half_float_trough_estimator_core.sv */
// ----------------------------------------------------------------------------
// half_float_trough_estimator_core
// Scan scheduler and running-minimum trough estimator for binary16 heights.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one word per frame tick (command 0) or height texel
//          (command 1). out_ch returns one word for every frame tick (the scan
//          decision) and one for every texel flagged last_of_tile (the trough
//          estimate); other texels give no word.
//   scan_interval_we / scan_interval_wdata load the scan interval register;
//   write it only while the block is idle.
//   Each word is captured in an input register and passes through a single
//   decode/compare/accumulate step into the result register, which drives
//   out_ch.valid. One word is accepted per cycle while out_ch does not stall
//   with a result held.
//   If out_ch stalls with a result held, the input register fills and
//   in_ch.ready drops; texels that give no result still drain.
//   Reset clears the cooldown, running minimum, sum and infinity flag, and
//   loads the scan interval with 15.
// ----------------------------------------------------------------------------
module half_float_trough_estimator_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            scan_interval_we,
    input  logic [hfte_pkg::INTERVAL_W-1:0] scan_interval_wdata,
    hfte_in_if.sink                         in_ch,
    hfte_out_if.source                      out_ch
);
    import hfte_pkg::*;

    // input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              command_reg;
    logic              tile_ready_reg;
    logic [HALF_W-1:0] height_half_reg;
    logic              last_of_cascade_reg;
    logic              last_of_tile_reg;

    // state
    logic [INTERVAL_W-1:0] scan_interval_reg;
    logic [INTERVAL_W-1:0] cooldown_reg;
    logic [INTERVAL_W-1:0] cooldown_next;
    logic [MAG_W-1:0]      deepest_reg;
    logic [MAG_W-1:0]      deepest_next;
    logic [TROUGH_W-1:0]   sum_reg;
    logic [TROUGH_W-1:0]   sum_next;
    logic                  infinite_reg;
    logic                  infinite_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                kind_reg;
    logic                scan_now_reg;
    logic [TROUGH_W-1:0] trough_reg;
    logic                trough_infinite_reg;
    logic                kind_next;
    logic                scan_now_next;
    logic [TROUGH_W-1:0] trough_next;
    logic                trough_infinite_next;

    hfte_decode_t          dec;
    logic                  in_take;
    logic                  has_result;
    logic                  s1_adv;
    logic                  due;
    logic [MAG_W-1:0]      deepest_upd;
    logic                  infinite_upd;
    logic [TROUGH_W:0]     sum_raw;
    logic [TROUGH_W-1:0]   sum_fold;

    hfte_decode u_decode
    (
        .height_half (height_half_reg),
        .dec         (dec)
    );

    assign has_result    = (command_reg == CMD_TICK) || last_of_tile_reg;
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || out_ch.ready || !has_result);
    assign in_ch.ready   = !s1_valid_reg || s1_adv;
    assign in_take       = in_ch.valid && in_ch.ready;
    assign s1_valid_next = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    assign due = (cooldown_reg == '0) && tile_ready_reg;

    assign deepest_upd  = (dec.neg_finite && (dec.mag > deepest_reg)) ? dec.mag : deepest_reg;
    assign infinite_upd = infinite_reg || dec.neg_inf;
    assign sum_raw      = {1'b0, sum_reg} + (TROUGH_W + 1)'(deepest_upd);
    assign sum_fold     = (sum_raw > {1'b0, TROUGH_CAP}) ? TROUGH_CAP : sum_raw[TROUGH_W-1:0];

    always_comb
    begin
        cooldown_next        = cooldown_reg;
        deepest_next         = deepest_reg;
        sum_next             = sum_reg;
        infinite_next        = infinite_reg;
        kind_next            = KIND_DECISION;
        scan_now_next        = 1'b0;
        trough_next          = '0;
        trough_infinite_next = 1'b0;
        if (command_reg == CMD_TICK)
        begin
            scan_now_next = due;
            if (due)
            begin
                cooldown_next = scan_interval_reg;
            end
            else if (cooldown_reg != '0)
            begin
                cooldown_next = cooldown_reg - INTERVAL_W'(1);
            end
        end
        else
        begin
            kind_next     = KIND_TROUGH;
            deepest_next  = deepest_upd;
            infinite_next = infinite_upd;
            if (last_of_cascade_reg || last_of_tile_reg)
            begin
                sum_next     = sum_fold;
                deepest_next = '0;
            end
            trough_next          = infinite_upd ? TROUGH_CAP : sum_fold;
            trough_infinite_next = infinite_upd;
            if (last_of_tile_reg)
            begin
                sum_next      = '0;
                infinite_next = 1'b0;
            end
        end
    end

    assign out_valid_next = (s1_adv && has_result) ? 1'b1 :
                            (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            scan_interval_reg <= SCAN_INTERVAL_RESET;
            cooldown_reg      <= '0;
            deepest_reg       <= '0;
            sum_reg           <= '0;
            infinite_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (scan_interval_we)
            begin
                scan_interval_reg <= scan_interval_wdata;
            end
            if (s1_adv)
            begin
                cooldown_reg <= cooldown_next;
                deepest_reg  <= deepest_next;
                sum_reg      <= sum_next;
                infinite_reg <= infinite_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            command_reg         <= in_ch.command;
            tile_ready_reg      <= in_ch.tile_ready;
            height_half_reg     <= in_ch.height_half;
            last_of_cascade_reg <= in_ch.last_of_cascade;
            last_of_tile_reg    <= in_ch.last_of_tile;
        end
        if (s1_adv && has_result)
        begin
            kind_reg            <= kind_next;
            scan_now_reg        <= scan_now_next;
            trough_reg          <= trough_next;
            trough_infinite_reg <= trough_infinite_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.kind            = kind_reg;
    assign out_ch.scan_now        = scan_now_reg;
    assign out_ch.trough          = trough_reg;
    assign out_ch.trough_infinite = trough_infinite_reg;

`ifndef NO_ASSERTIONS
    a_decision_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_DECISION) |->
            (trough_reg == '0 && !trough_infinite_reg))
        else $error("scan decision carries trough data");

    a_estimate_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_TROUGH) |-> !scan_now_reg)
        else $error("trough estimate carries scan_now");

    a_sum_capped: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= TROUGH_CAP)
        else $error("trough sum above cap");

    a_infinite_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && trough_infinite_reg) |-> (trough_reg == TROUGH_CAP))
        else $error("infinite estimate not at cap");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stalled word lost from input register");
`endif

endmodule

/* hdl/hfte_decode.sv */
// ----------------------------------------------------------------------------
// hfte_decode
// Classifies a binary16 height and decodes its magnitude to 2^-24 fixed point.
// ----------------------------------------------------------------------------
module hfte_decode
(
    input  logic [hfte_pkg::HALF_W-1:0] height_half,
    output hfte_pkg::hfte_decode_t      dec
);
    import hfte_pkg::*;

    logic [4:0] exp_field;
    logic [9:0] man_field;
    logic       negative;
    logic       exp_all_ones;

    assign exp_field    = height_half[14:10];
    assign man_field    = height_half[9:0];
    assign negative     = (height_half & HALF_SIGN_BIT) != '0;
    assign exp_all_ones = (height_half & HALF_EXP_MASK) == HALF_EXP_MASK;

    always_comb
    begin
        dec.neg_inf    = negative && exp_all_ones && (man_field == '0);
        dec.neg_finite = negative && !exp_all_ones && ((height_half & HALF_MAG_MASK) != '0);
        if (exp_field == '0)
        begin
            dec.mag = MAG_W'(man_field);   // subnormal
        end
        else
        begin
            dec.mag = MAG_W'({1'b1, man_field}) << (exp_field - 5'd1);
        end
    end

endmodule
